/* rtl/core/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the command line tokenizer
// Transaction payloads, character classes, result kinds, shared-unit
// operation codes and sequencer states.
// ----------------------------------------------------------------------------
package clt_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } clt_in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [31:0] item_value;
    logic        final_item;
  } clt_out_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_PARAM  = 2'd2;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_UPPER_X = 8'd88;
  localparam logic [7:0] CHAR_LOWER_X = 8'd120;

  // Digit offsets for decimal digits, upper-case hex letters, other bytes in hex mode
  localparam logic [31:0] OFS_DEC   = 32'd48;
  localparam logic [31:0] OFS_UPPER = 32'd55;
  localparam logic [31:0] OFS_LOWER = 32'd87;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_SPACE,
    CLS_LETTER,
    CLS_DIGIT
  } char_class_e;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_DIGIT,
    ALU_SCALE,
    ALU_SUM
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    logic       hex;
    logic [7:0] ch;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_SCALE,
    ST_SUM,
    ST_HEADER,
    ST_WORD_RD,
    ST_WORD_OUT,
    ST_NUM_RD,
    ST_NUM_OUT
  } state_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c >= 8'd65) && (c <= 8'd70);
  endfunction

  function automatic logic is_hex_like(input logic [7:0] c);
    return is_digit(c) || is_upper_hex(c) || ((c >= 8'd97) && (c <= 8'd102));
  endfunction

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    if (c == CHAR_SPACE) begin
      cls = CLS_SPACE;
    end else if (((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122))) begin
      cls = CLS_LETTER;
    end else if (is_digit(c)) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

/* rtl/core/clt_alu.sv */
// ----------------------------------------------------------------------------
// clt_alu: shared 32-bit adder of the tokenizer
// One adder, reused for the digit value, the x10 / x16 scale and the sum.
// ----------------------------------------------------------------------------
module clt_alu
  import clt_pkg::*;
(
  input  logic        clk_i,
  input  alu_req_t    req_i,
  input  logic [31:0] value_i,
  output logic [31:0] sum_o,
  output logic [31:0] digit_o
);

  logic [31:0] d_q;
  logic [31:0] m_q;
  logic [31:0] ofs;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] sum;

  always_comb begin
    if (is_digit(req_i.ch)) begin
      ofs = OFS_DEC;
    end else if (req_i.hex && is_upper_hex(req_i.ch)) begin
      ofs = OFS_UPPER;
    end else if (req_i.hex) begin
      ofs = OFS_LOWER;
    end else begin
      ofs = OFS_DEC;
    end
  end

  always_comb begin
    unique case (req_i.op)
      ALU_DIGIT: begin
        opa = {{24{req_i.ch[7]}}, req_i.ch};
        opb = 32'd0 - ofs;
      end
      ALU_SCALE: begin
        // x16 is one shift; x10 is x8 plus x2
        opa = req_i.hex ? {value_i[27:0], 4'b0000} : {value_i[28:0], 3'b000};
        opb = req_i.hex ? 32'd0 : {value_i[30:0], 1'b0};
      end
      ALU_SUM: begin
        opa = m_q;
        opb = d_q;
      end
      default: begin
        opa = 32'd0;
        opb = 32'd0;
      end
    endcase
  end

  assign sum = opa + opb;

  always_ff @(posedge clk_i) begin
    if (req_i.op == ALU_DIGIT) begin
      d_q <= sum;
    end
    if (req_i.op == ALU_SCALE) begin
      m_q <= sum;
    end
  end

  assign sum_o   = sum;
  assign digit_o = d_q;

endmodule

/* rtl/core/clt_ram.sv */
// ----------------------------------------------------------------------------
// clt_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/command_line_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// command_line_tokenizer_core: line tokenizer, command word plus numbers
// Collects one command word and its decimal or hex parameters from a text
// line, then reads them out as a header, command characters and values.
// ----------------------------------------------------------------------------
// Feed one line byte per input transaction; the byte flagged line_end is not
// examined but starts readout. A letter after a space opens the command word
// (dropping earlier numbers), a digit after a space opens a parameter once
// a command word is open, hex when it is "0x"/"0X". Values wrap mod 2^32.
// Each ordinary byte is captured, then passes three times through the single
// shared 32-bit adder (digit offset, x10 or x16 scale by shift-add, final
// sum) while the input stalls. Readout gives the header, then each command
// character or parameter after a registered read of the word or number RAM,
// and waits while the output side stalls. Results sit in an output register,
// so the last result may still wait while the next line's first byte is
// taken. No clearing pass follows reset. Extra parameters beyond MAX_FIELDS-1
// are dropped and the command word is cut at WORD_CHARS characters.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core
  import clt_pkg::*;
#(
  parameter int MAX_FIELDS = 10,
  parameter int WORD_CHARS = 31
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  clt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output clt_out_t out_data_o
);

  localparam int WA        = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
  localparam int FW        = $clog2(WORD_CHARS + 1);
  localparam int NUM_DEPTH = MAX_FIELDS - 1;
  localparam int NA        = (NUM_DEPTH > 1) ? $clog2(NUM_DEPTH) : 1;
  localparam int CW        = $clog2(MAX_FIELDS + 1);

  localparam logic [CW-1:0] FC_MAX   = CW'(MAX_FIELDS);
  localparam logic [FW-1:0] WORD_MAX = FW'(WORD_CHARS);

  // Sequencer and capture
  state_e            state_q, state_d;
  logic [7:0]        ch_q, ch_d;

  // Line state
  char_class_e       prev_class_q, prev_class_d;
  logic [CW-1:0]     field_count_q, field_count_d;
  logic              word_open_q, word_open_d;
  logic [FW-1:0]     word_length_q, word_length_d;
  logic [FW-1:0]     word_fill_q, word_fill_d;
  logic [31:0]       running_q, running_d;
  logic              hex_mode_q, hex_mode_d;
  logic              zero_pending_q, zero_pending_d;
  logic              hex_first_q, hex_first_d;
  logic              num_closed_q, num_closed_d;
  logic [7:0]        prev_char_q, prev_char_d;

  // Readout counters
  logic [FW-1:0]     wcnt_q, wcnt_d;
  logic [CW-1:0]     ncnt_q, ncnt_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  clt_out_t          out_q, out_d;
  logic              out_free;
  logic              out_load;

  // Shared unit and stores
  alu_req_t          alu_req;
  logic [31:0]       alu_sum;
  logic [31:0]       alu_digit;

  logic              w_we;
  logic [WA-1:0]     w_waddr;
  logic [WA-1:0]     w_raddr;
  logic [7:0]        w_rdata;
  logic              n_we;
  logic [NA-1:0]     n_waddr;
  logic [NA-1:0]     n_raddr;
  logic [31:0]       n_wdata;
  logic [31:0]       n_rdata;

  char_class_e       cls;
  logic              skip_x;
  logic              line_done;
  logic              hdr_final;
  logic              last_w;
  logic              last_n;

  clt_alu u_alu (
    .clk_i   (clk_i),
    .req_i   (alu_req),
    .value_i (running_q),
    .sum_o   (alu_sum),
    .digit_o (alu_digit)
  );

  clt_ram #(
    .WIDTH (8),
    .DEPTH (WORD_CHARS),
    .AW    (WA)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (ch_q),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  clt_ram #(
    .WIDTH (32),
    .DEPTH (NUM_DEPTH),
    .AW    (NA)
  ) u_num_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cls        = classify(ch_q);
  // Header is the only result when there is no command, or no command characters and no parameters
  assign hdr_final  = (field_count_q == '0) ||
                      ((field_count_q == CW'(1)) && (word_length_q == '0));
  assign last_w     = (wcnt_q == (word_length_q - FW'(1)));
  assign last_n     = (ncnt_q == (field_count_q - CW'(2)));
  assign w_raddr    = WA'(wcnt_q);
  assign n_raddr    = NA'(ncnt_q);

  always_comb begin
    state_d        = state_q;
    ch_d           = ch_q;
    prev_class_d   = prev_class_q;
    field_count_d  = field_count_q;
    word_open_d    = word_open_q;
    word_length_d  = word_length_q;
    word_fill_d    = word_fill_q;
    running_d      = running_q;
    hex_mode_d     = hex_mode_q;
    zero_pending_d = zero_pending_q;
    hex_first_d    = hex_first_q;
    num_closed_d   = num_closed_q;
    prev_char_d    = prev_char_q;
    wcnt_d         = wcnt_q;
    ncnt_d         = ncnt_q;
    out_d          = out_q;
    out_load       = 1'b0;
    line_done      = 1'b0;
    skip_x         = 1'b0;
    w_we           = 1'b0;
    w_waddr        = '0;
    n_we           = 1'b0;
    n_waddr        = '0;
    n_wdata        = alu_digit;
    alu_req.op     = ALU_HOLD;
    alu_req.hex    = hex_mode_q;
    alu_req.ch     = ch_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d    = in_data_i.char_code;
          state_d = in_data_i.line_end ? ST_HEADER : ST_DIGIT;
        end
      end

      ST_DIGIT: begin
        alu_req.op = ALU_DIGIT;
        state_d    = ST_SCALE;
      end

      ST_SCALE: begin
        alu_req.op = ALU_SCALE;
        state_d    = ST_SUM;
      end

      ST_SUM: begin
        alu_req.op = ALU_SUM;
        state_d    = ST_IDLE;

        // A '0' that opened a parameter turns it hex when an x follows
        if (zero_pending_q) begin
          zero_pending_d = 1'b0;
          if ((ch_q == CHAR_LOWER_X) || (ch_q == CHAR_UPPER_X)) begin
            hex_mode_d  = 1'b1;
            hex_first_d = 1'b1;
            running_d   = 32'd0;
            skip_x      = 1'b1;
          end
        end

        if ((prev_class_q == CLS_SPACE) && (cls == CLS_LETTER)) begin
          // Open a new command word, drop all parameters
          field_count_d = CW'(1);
          word_open_d   = 1'b1;
          w_we          = 1'b1;
          w_waddr       = '0;
          word_fill_d   = FW'(1);
          word_length_d = FW'(1);
          num_closed_d  = 1'b0;
          hex_first_d   = 1'b0;
          hex_mode_d    = 1'b0;
        end else if ((prev_class_q == CLS_SPACE) && (cls == CLS_DIGIT) &&
                     (field_count_q != '0)) begin
          if (field_count_q < FC_MAX) begin
            // Open a new parameter
            field_count_d  = field_count_q + CW'(1);
            word_open_d    = 1'b0;
            num_closed_d   = 1'b0;
            hex_mode_d     = 1'b0;
            hex_first_d    = 1'b0;
            running_d      = alu_digit;
            n_we           = 1'b1;
            n_waddr        = NA'(field_count_q - CW'(1));
            n_wdata        = alu_digit;
            zero_pending_d = (ch_q == CHAR_ZERO);
          end else begin
            // Parameter list full: freeze the last one
            num_closed_d = 1'b1;
          end
        end else if (word_open_q && (field_count_q == CW'(1))) begin
          if (word_fill_q < WORD_MAX) begin
            w_we        = 1'b1;
            w_waddr     = WA'(word_fill_q);
            word_fill_d = word_fill_q + FW'(1);
          end
          if ((prev_class_q == CLS_LETTER) && (cls == CLS_LETTER)) begin
            word_length_d = word_fill_d;
          end
        end else if ((field_count_q > CW'(1)) && !num_closed_q && !skip_x) begin
          n_waddr = NA'(field_count_q - CW'(2));
          if (hex_first_q) begin
            // First hex position: a non-hex byte there counts as zero
            hex_first_d = 1'b0;
            running_d   = alu_digit;
            n_we        = 1'b1;
            n_wdata     = is_hex_like(ch_q) ? alu_digit : 32'd0;
          end else begin
            running_d = alu_sum;
            if (is_hex_like(prev_char_q) && is_hex_like(ch_q)) begin
              n_we    = 1'b1;
              n_wdata = alu_sum;
            end
          end
        end

        prev_class_d = cls;
        prev_char_d  = ch_q;
      end

      ST_HEADER: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.item_kind  = KIND_HEADER;
          out_d.item_value = 32'(field_count_q);
          out_d.final_item = hdr_final;
          wcnt_d           = '0;
          ncnt_d           = '0;
          if ((field_count_q != '0) && (word_length_q != '0)) begin
            state_d = ST_WORD_RD;
          end else if (field_count_q > CW'(1)) begin
            state_d = ST_NUM_RD;
          end else begin
            line_done = 1'b1;
          end
        end
      end

      ST_WORD_RD: begin
        state_d = ST_WORD_OUT;
      end

      ST_WORD_OUT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.item_kind  = KIND_CHAR;
          out_d.item_value = 32'(w_rdata);
          out_d.final_item = last_w && (field_count_q < CW'(2));
          if (last_w) begin
            if (field_count_q > CW'(1)) begin
              state_d = ST_NUM_RD;
            end else begin
              line_done = 1'b1;
            end
          end else begin
            wcnt_d  = wcnt_q + FW'(1);
            state_d = ST_WORD_RD;
          end
        end
      end

      ST_NUM_RD: begin
        state_d = ST_NUM_OUT;
      end

      ST_NUM_OUT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.item_kind  = KIND_PARAM;
          out_d.item_value = n_rdata;
          out_d.final_item = last_n;
          if (last_n) begin
            line_done = 1'b1;
          end else begin
            ncnt_d  = ncnt_q + CW'(1);
            state_d = ST_NUM_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Return the line state to its start values after readout
    if (line_done) begin
      state_d        = ST_IDLE;
      prev_class_d   = CLS_SPACE;
      field_count_d  = '0;
      word_open_d    = 1'b0;
      word_length_d  = '0;
      word_fill_d    = '0;
      running_d      = 32'd0;
      hex_mode_d     = 1'b0;
      zero_pending_d = 1'b0;
      hex_first_d    = 1'b0;
      num_closed_d   = 1'b0;
      prev_char_d    = CHAR_SPACE;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      ch_q           <= CHAR_SPACE;
      prev_class_q   <= CLS_SPACE;
      field_count_q  <= '0;
      word_open_q    <= 1'b0;
      word_length_q  <= '0;
      word_fill_q    <= '0;
      running_q      <= 32'd0;
      hex_mode_q     <= 1'b0;
      zero_pending_q <= 1'b0;
      hex_first_q    <= 1'b0;
      num_closed_q   <= 1'b0;
      prev_char_q    <= CHAR_SPACE;
      wcnt_q         <= '0;
      ncnt_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      ch_q           <= ch_d;
      prev_class_q   <= prev_class_d;
      field_count_q  <= field_count_d;
      word_open_q    <= word_open_d;
      word_length_q  <= word_length_d;
      word_fill_q    <= word_fill_d;
      running_q      <= running_d;
      hex_mode_q     <= hex_mode_d;
      zero_pending_q <= zero_pending_d;
      hex_first_q    <= hex_first_d;
      num_closed_q   <= num_closed_d;
      prev_char_q    <= prev_char_d;
      wcnt_q         <= wcnt_d;
      ncnt_q         <= ncnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Output payload: no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The visible command length never runs past the stored characters
  a_len_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_length_q <= word_fill_q)
    else $error("command length beyond stored characters");

  // Field count saturates at the configured maximum
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_count_q <= FC_MAX)
    else $error("field count above maximum");

  // A new result only appears from one of the readout steps
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_HEADER || state_q == ST_WORD_OUT ||
                                 state_q == ST_NUM_OUT))
    else $error("result issued outside readout");

  // An ordinary byte always starts the adder sequence
  a_byte_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_data_i.line_end) |=> (state_q == ST_DIGIT))
    else $error("byte transaction did not start examination");

endmodule
